FILE: hdl/rfr_pkg.sv
// Shared types, constants and saturating Q24.24 helpers for the regula falsi root block.
// Depends on nothing; every other file imports it.
package rfr_pkg;

    localparam int VW     = 48;             // value width
    localparam int FB     = 24;             // fraction bits
    localparam int CW     = 16;             // count width
    localparam int MAXDEG = 63;
    localparam int AW     = $clog2(MAXDEG + 1);
    localparam int KW     = AW + 1;         // derivative scale factor width
    localparam int MW     = 2 * VW;         // wide magnitude width
    localparam int NW     = VW + FB;        // dividend width

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam t_val QONE = {{(VW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [1:0] MODE_FIXED    = 2'd0;
    localparam logic [1:0] MODE_APRIORI  = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;
    localparam logic [1:0] MODE_STEP     = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_CAP     = 2'd1;
    localparam logic [1:0] STAT_FLAT    = 2'd2;
    localparam logic [1:0] STAT_M1ZERO  = 2'd3;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_LATCH,
        DP_ACC_ZERO, DP_ACC_DC, DP_ACC_ADD,
        DP_ST_D1LO, DP_ST_D1HI, DP_ST_D2LO, DP_ST_F0LO, DP_ST_FFAR, DP_ST_FX,
        DP_SLOPE, DP_CLR_ERR,
        DP_DIV_C, DP_SAVE_C, DP_DIV_Q, DP_SAVE_Q,
        DP_MUL_H, DP_MUL_P, DP_STEP,
        DP_DIV_E, DP_SAVE_E, DP_MUL_T, DP_SAVE_T
    } t_dp_op;

    typedef enum logic [1:0] {PT_LO, PT_HI, PT_CUR, PT_FAR} t_pt;

    typedef struct packed {
        t_dp_op        op;
        t_pt           pt;
        logic [1:0]    order;
        logic [AW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic m1_zero;
        logic den_zero;
        logic go_apriori;
        logic go_weighted;
        logic go_step;
    } t_sts;

    function automatic t_val f_add(t_val a, t_val b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) f_add = s[VW] ? VMIN : VMAX;
        else                  f_add = s[VW-1:0];
    endfunction

    function automatic t_val f_sub(t_val a, t_val b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1]) f_sub = s[VW] ? VMIN : VMAX;
        else                  f_sub = s[VW-1:0];
    endfunction

    function automatic t_val f_abs(t_val v);
        if (v == VMIN)    f_abs = VMAX;
        else if (v < 0)   f_abs = -v;
        else              f_abs = v;
    endfunction

    function automatic logic [VW-1:0] f_mag(t_val v);
        logic [VW-1:0] u;
        u = v;
        f_mag = v[VW-1] ? (~u + 1'b1) : u;
    endfunction

    // sign plus wide magnitude back to a saturated value
    function automatic t_val f_make(logic neg, logic [MW-1:0] m);
        logic [VW-1:0] low;
        low = m[VW-1:0];
        if (m > {{(MW-VW){1'b0}}, VMAX}) f_make = neg ? VMIN : VMAX;
        else if (neg)                    f_make = t_val'(~low + 1'b1);
        else                             f_make = t_val'(low);
    endfunction

    function automatic t_val f_scale(t_val v, logic [KW-1:0] k);
        logic [VW+KW-1:0] p;
        p = f_mag(v) * k;
        f_scale = f_make(v[VW-1], {{(MW-VW-KW){1'b0}}, p});
    endfunction

endpackage

FILE: hdl/rfr_mul.sv
// Shift-add fixed-point multiplier, one multiplier bit per cycle, saturated Q result.
// Depends on rfr_pkg.
module rfr_mul import rfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_val i_a,
    input  t_val i_b,
    output logic o_busy,
    output t_val o_result
);
    localparam int CNTW = $clog2(VW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_mcand, r_hi, r_lo;
    logic            r_neg;
    logic [VW:0]     sum;
    logic [MW-1:0]   prod;

    assign sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(VW+1){1'b0}});
    assign prod = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNTW'(VW - 1)) r_busy <= 1'b0;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= f_mag(i_a);
            r_lo    <= f_mag(i_b);
            r_hi    <= '0;
            r_neg   <= i_a[VW-1] ^ i_b[VW-1];
        end else if (r_busy) begin
            r_hi <= sum[VW:1];
            r_lo <= {sum[0], r_lo[VW-1:1]};
        end
    end

    assign o_busy   = r_busy;
    assign o_result = f_make(r_neg, prod >> FB);

endmodule

FILE: hdl/rfr_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, saturated Q result.
// Depends on rfr_pkg.
module rfr_div import rfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_val i_num,
    input  t_val i_den,
    output logic o_busy,
    output t_val o_result
);
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_num;
    logic [VW-1:0]   r_rem, r_den;
    logic            r_neg, r_xneg, r_xnz;
    logic [VW:0]     trial, diff;
    logic            ge;

    assign trial = {r_rem, r_num[NW-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNTW'(NW - 1)) r_busy <= 1'b0;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {f_mag(i_num), {FB{1'b0}}};
            r_rem  <= '0;
            r_den  <= f_mag(i_den);
            r_neg  <= i_num[VW-1] ^ i_den[VW-1];
            r_xneg <= i_num[VW-1];
            r_xnz  <= i_num != '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_num <= {r_num[NW-2:0], ge};
        end
    end

    always_comb begin
        if (r_den == '0) o_result = r_xneg ? VMIN : (r_xnz ? VMAX : '0);
        else             o_result = f_make(r_neg, {{(MW-NW){1'b0}}, r_num});
    end

    assign o_busy = r_busy;

endmodule

FILE: hdl/rfr_dp.sv
// Datapath: coefficient memory, derivative scaling pipe, Horner accumulator, value registers.
// Depends on rfr_pkg, rfr_mul and rfr_div.
module rfr_dp import rfr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_coef_index,
    input  t_val          i_coef_value,
    input  t_val          i_lo,
    input  t_val          i_hi,
    input  logic [VW-2:0] i_tol,
    output t_sts          o_sts,
    output t_val          o_root,
    output logic [VW-2:0] o_err_apriori,
    output logic [VW-2:0] o_err_posterior
);
    logic [VW-1:0] mem [MAXDEG+1];
    logic [VW-1:0] r_rd;
    t_val r_s1, r_dc;
    t_val r_lo, r_hi, r_tol, r_acc;
    t_val r_d1lo, r_d1hi, r_d2lo, r_f0lo, r_ffar, r_fx;
    t_val r_m1, r_big, r_cur, r_far, r_prev, r_c, r_q, r_ea, r_t;

    logic [AW-1:0] rd_addr;
    logic [KW-1:0] k1, k2, idx_w;
    t_val pt_val, den, step, two_m1, m1_new, big_new, ep_val;
    t_val mul_a, mul_b, mul_res, div_n, div_d, div_res;
    logic mul_start, div_start, mul_busy, div_busy, far_is_hi;

    function automatic logic [VW-2:0] f_errout(t_val v);
        f_errout = (v <= 0) ? '0 : v[VW-2:0];
    endfunction

    // derivative coefficient: c[i+order] scaled by (i+1) for order 1, by (i+1) and (i+2) for order 2
    assign idx_w   = {1'b0, i_cmd.idx};
    assign rd_addr = AW'(idx_w + KW'(i_cmd.order));

    always_comb begin
        case (i_cmd.order)
            2'd0:    k1 = KW'(1);
            2'd1:    k1 = idx_w + KW'(1);
            default: k1 = idx_w + KW'(2);
        endcase
        k2 = (i_cmd.order == 2'd2) ? (idx_w + KW'(1)) : KW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LOAD) mem[i_coef_index] <= i_coef_value;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= f_scale(t_val'(r_rd), k1);
        r_dc <= f_scale(r_s1, k2);
    end

    always_comb begin
        case (i_cmd.pt)
            PT_LO:   pt_val = r_lo;
            PT_HI:   pt_val = r_hi;
            PT_CUR:  pt_val = r_cur;
            default: pt_val = r_far;
        endcase
    end

    assign den    = f_sub(r_ffar, r_fx);
    assign step   = f_abs(f_sub(r_cur, r_prev));
    assign two_m1 = f_add(r_m1, r_m1);
    assign ep_val = (r_big <= two_m1) ? step : r_t;

    // slope bounds from the derivative signs at the low end
    always_comb begin
        if (r_d2lo > 0 && r_d1lo > 0)       m1_new = r_d1lo;
        else if (r_d2lo > 0 && r_d1lo < 0)  m1_new = f_sub('0, r_d1hi);
        else if (r_d2lo <= 0 && r_d1lo > 0) m1_new = r_d1hi;
        else                                m1_new = f_sub('0, r_d1lo);
        big_new   = (m1_new == f_abs(r_d1lo)) ? f_abs(r_d1hi) : f_abs(r_d1lo);
        far_is_hi = (r_f0lo > 0 && r_d2lo < 0) || (r_f0lo < 0 && r_d2lo > 0);
    end

    always_comb begin
        mul_start = 1'b1;
        case (i_cmd.op)
            DP_MUL_H: begin mul_a = r_acc; mul_b = pt_val; end
            DP_MUL_P: begin mul_a = r_fx;  mul_b = r_q;    end
            DP_MUL_T: begin mul_a = r_c;   mul_b = step;   end
            default: begin
                mul_a     = r_c;
                mul_b     = step;
                mul_start = 1'b0;
            end
        endcase
        div_start = 1'b1;
        case (i_cmd.op)
            DP_DIV_C: begin div_n = f_sub(r_big, r_m1);  div_d = r_m1; end
            DP_DIV_Q: begin div_n = f_sub(r_far, r_cur); div_d = den;  end
            DP_DIV_E: begin div_n = f_abs(r_fx);         div_d = r_m1; end
            default: begin
                div_n     = f_abs(r_fx);
                div_d     = r_m1;
                div_start = 1'b0;
            end
        endcase
    end

    rfr_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_busy   (mul_busy),
        .o_result (mul_res)
    );

    rfr_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_n),
        .i_den    (div_d),
        .o_busy   (div_busy),
        .o_result (div_res)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_lo  <= i_lo;
                r_hi  <= i_hi;
                r_tol <= t_val'({1'b0, i_tol});
            end
            DP_ACC_ZERO: r_acc  <= '0;
            DP_ACC_DC:   r_acc  <= r_dc;
            DP_ACC_ADD:  r_acc  <= f_add(mul_res, r_dc);
            DP_ST_D1LO:  r_d1lo <= r_acc;
            DP_ST_D1HI:  r_d1hi <= r_acc;
            DP_ST_D2LO:  r_d2lo <= r_acc;
            DP_ST_F0LO:  r_f0lo <= r_acc;
            DP_ST_FFAR:  r_ffar <= r_acc;
            DP_ST_FX:    r_fx   <= r_acc;
            DP_SLOPE: begin
                r_m1   <= m1_new;
                r_big  <= big_new;
                r_cur  <= far_is_hi ? r_lo : r_hi;
                r_prev <= far_is_hi ? r_lo : r_hi;
                r_far  <= far_is_hi ? r_hi : r_lo;
            end
            DP_CLR_ERR: begin
                r_ea <= '0;
                r_t  <= '0;
            end
            DP_SAVE_C: r_c <= div_res;
            DP_SAVE_Q: r_q <= div_res;
            DP_STEP: begin
                r_prev <= r_cur;
                r_cur  <= f_sub(r_cur, mul_res);
            end
            DP_SAVE_E: r_ea <= div_res;
            DP_SAVE_T: r_t  <= mul_res;
            default: ;
        endcase
    end

    always_comb begin
        o_sts.mul_busy    = mul_busy;
        o_sts.div_busy    = div_busy;
        o_sts.m1_zero     = r_m1 == '0;
        o_sts.den_zero    = den == '0;
        o_sts.go_apriori  = r_ea >= r_tol;
        o_sts.go_weighted = (r_c <= QONE) ? (step > r_tol) : (r_t > r_tol);
        o_sts.go_step     = step >= r_tol;
    end

    assign o_root          = r_cur;
    assign o_err_apriori   = f_errout(r_ea);
    assign o_err_posterior = f_errout(ep_val);

endmodule

FILE: hdl/rfr_ctrl.sv
// Controller: sequences Horner passes, slope setup, regula falsi steps and stop tests.
// Depends on rfr_pkg; drives rfr_dp through t_cmd and reads t_sts back.
module rfr_ctrl import rfr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    input  logic [1:0]    i_mode,
    input  logic [CW-1:0] i_count,
    input  logic [AW-1:0] i_degree,
    input  logic [CW-1:0] i_cap,
    input  logic          i_out_free,
    input  t_sts          i_sts,
    output logic          o_ready,
    output t_cmd          o_cmd,
    output logic          o_done,
    output logic [1:0]    o_status,
    output logic [CW-1:0] o_iters
);
    typedef enum logic [4:0] {
        S_IDLE, S_EV_BEGIN, S_EV_FETCH, S_EV_LOAD, S_EV_MUL, S_EV_MULW, S_EV_STORE,
        S_SLOPE, S_CHK_M1, S_DIVC, S_DIVC_W, S_SAVEC, S_LOOP,
        S_DIVQ, S_DIVQ_W, S_SAVEQ, S_MULP, S_MULP_W, S_UPDATE,
        S_TEST, S_DIVE, S_DIVE_W, S_SAVEE, S_MULT, S_MULT_W, S_SAVET, S_DECIDE, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_D1LO, PH_D1HI, PH_D2LO, PH_F0LO, PH_FFAR, PH_FX0, PH_FX
    } t_phase;

    t_state        r_state;
    t_phase        r_phase;
    t_pt           r_pt;
    logic [1:0]    r_order;
    logic [AW-1:0] r_idx;
    logic [1:0]    r_fetch;
    logic          r_first, r_final;
    logic [1:0]    r_mode, r_status;
    logic [CW-1:0] r_cnt, r_steps;
    logic          no_terms, go;
    t_dp_op        op;

    assign no_terms = {1'b0, i_degree} < {{(AW-1){1'b0}}, r_order};

    always_comb begin
        case (r_mode)
            MODE_APRIORI:  go = i_sts.go_apriori;
            MODE_WEIGHTED: go = i_sts.go_weighted;
            default:       go = i_sts.go_step;
        endcase
    end

    always_comb begin
        op = DP_NOP;
        unique case (r_state)
            S_IDLE:     if (i_accept) op = (i_op == OP_LOAD) ? DP_LOAD : DP_LATCH;
            S_EV_BEGIN: if (no_terms) op = DP_ACC_ZERO;
            S_EV_LOAD:  op = r_first ? DP_ACC_DC : DP_ACC_ADD;
            S_EV_MUL:   op = DP_MUL_H;
            S_EV_STORE: begin
                unique case (r_phase)
                    PH_D1LO: op = DP_ST_D1LO;
                    PH_D1HI: op = DP_ST_D1HI;
                    PH_D2LO: op = DP_ST_D2LO;
                    PH_F0LO: op = DP_ST_F0LO;
                    PH_FFAR: op = DP_ST_FFAR;
                    default: op = DP_ST_FX;
                endcase
            end
            S_SLOPE:    op = DP_SLOPE;
            S_CHK_M1:   if (i_sts.m1_zero) op = DP_CLR_ERR;
            S_DIVC:     op = DP_DIV_C;
            S_SAVEC:    op = DP_SAVE_C;
            S_DIVQ:     op = DP_DIV_Q;
            S_SAVEQ:    op = DP_SAVE_Q;
            S_MULP:     op = DP_MUL_P;
            S_UPDATE:   op = DP_STEP;
            S_DIVE:     op = DP_DIV_E;
            S_SAVEE:    op = DP_SAVE_E;
            S_MULT:     op = DP_MUL_T;
            S_SAVET:    op = DP_SAVE_T;
            default:    op = DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_D1LO;
            r_pt     <= PT_LO;
            r_order  <= '0;
            r_idx    <= '0;
            r_fetch  <= '0;
            r_first  <= 1'b0;
            r_final  <= 1'b0;
            r_mode   <= MODE_FIXED;
            r_status <= STAT_DONE;
            r_cnt    <= '0;
            r_steps  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept && i_op == OP_SOLVE) begin
                        r_mode   <= i_mode;
                        r_cnt    <= i_count;
                        r_steps  <= '0;
                        r_status <= STAT_DONE;
                        r_final  <= 1'b0;
                        r_phase  <= PH_D1LO;
                        r_pt     <= PT_LO;
                        r_order  <= 2'd1;
                        r_state  <= S_EV_BEGIN;
                    end
                end
                S_EV_BEGIN: begin
                    if (no_terms) begin
                        r_state <= S_EV_STORE;
                    end else begin
                        r_idx   <= i_degree - AW'(r_order);
                        r_fetch <= '0;
                        r_first <= 1'b1;
                        r_state <= S_EV_FETCH;
                    end
                end
                S_EV_FETCH: begin
                    if (r_fetch == 2'd2) r_state <= S_EV_LOAD;
                    r_fetch <= r_fetch + 1'b1;
                end
                S_EV_LOAD: begin
                    r_first <= 1'b0;
                    r_state <= (r_idx == '0) ? S_EV_STORE : S_EV_MUL;
                end
                S_EV_MUL: r_state <= S_EV_MULW;
                S_EV_MULW: begin
                    if (!i_sts.mul_busy) begin
                        r_idx   <= r_idx - 1'b1;
                        r_fetch <= '0;
                        r_state <= S_EV_FETCH;
                    end
                end
                S_EV_STORE: begin
                    unique case (r_phase)
                        PH_D1LO: begin
                            r_phase <= PH_D1HI;
                            r_pt    <= PT_HI;
                            r_state <= S_EV_BEGIN;
                        end
                        PH_D1HI: begin
                            r_phase <= PH_D2LO;
                            r_pt    <= PT_LO;
                            r_order <= 2'd2;
                            r_state <= S_EV_BEGIN;
                        end
                        PH_D2LO: begin
                            r_phase <= PH_F0LO;
                            r_order <= 2'd0;
                            r_state <= S_EV_BEGIN;
                        end
                        PH_F0LO: r_state <= S_SLOPE;
                        PH_FFAR: begin
                            r_phase <= PH_FX0;
                            r_pt    <= PT_CUR;
                            r_state <= S_EV_BEGIN;
                        end
                        PH_FX0:  r_state <= S_DIVC;
                        default: r_state <= S_TEST;
                    endcase
                end
                S_SLOPE: r_state <= S_CHK_M1;
                S_CHK_M1: begin
                    if (i_sts.m1_zero) begin
                        r_status <= STAT_M1ZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_phase <= PH_FFAR;
                        r_pt    <= PT_FAR;
                        r_order <= 2'd0;
                        r_state <= S_EV_BEGIN;
                    end
                end
                S_DIVC:   r_state <= S_DIVC_W;
                S_DIVC_W: if (!i_sts.div_busy) r_state <= S_SAVEC;
                S_SAVEC:  r_state <= S_LOOP;
                S_LOOP: begin
                    if (r_mode == MODE_FIXED && r_steps >= r_cnt) begin
                        r_final <= 1'b1;
                        r_state <= S_DIVE;
                    end else if (i_sts.den_zero) begin
                        r_status <= STAT_FLAT;
                        r_final  <= 1'b1;
                        r_state  <= S_DIVE;
                    end else begin
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ:   r_state <= S_DIVQ_W;
                S_DIVQ_W: if (!i_sts.div_busy) r_state <= S_SAVEQ;
                S_SAVEQ:  r_state <= S_MULP;
                S_MULP:   r_state <= S_MULP_W;
                S_MULP_W: if (!i_sts.mul_busy) r_state <= S_UPDATE;
                S_UPDATE: begin
                    r_steps <= r_steps + 1'b1;
                    r_phase <= PH_FX;
                    r_pt    <= PT_CUR;
                    r_order <= 2'd0;
                    r_state <= S_EV_BEGIN;
                end
                S_TEST:   r_state <= (r_mode == MODE_FIXED) ? S_LOOP : S_DIVE;
                S_DIVE:   r_state <= S_DIVE_W;
                S_DIVE_W: if (!i_sts.div_busy) r_state <= S_SAVEE;
                S_SAVEE:  r_state <= S_MULT;
                S_MULT:   r_state <= S_MULT_W;
                S_MULT_W: if (!i_sts.mul_busy) r_state <= S_SAVET;
                S_SAVET:  r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (r_final || !go) begin
                        r_state <= S_DONE;
                    end else if (r_steps >= i_cap) begin
                        r_status <= STAT_CAP;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_LOOP;
                    end
                end
                S_DONE: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready   = r_state == S_IDLE;
    assign o_done    = (r_state == S_DONE) && i_out_free;
    assign o_status  = r_status;
    assign o_iters   = r_steps;
    assign o_cmd.op    = op;
    assign o_cmd.pt    = r_pt;
    assign o_cmd.order = r_order;
    assign o_cmd.idx   = r_idx;

`ifndef SYNTHESIS
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_out_free)
        else $error("result handed over while output register full");

    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == DP_MUL_H || op == DP_MUL_P || op == DP_MUL_T) |-> !i_sts.mul_busy)
        else $error("multiplier restarted while busy");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == DP_DIV_C || op == DP_DIV_Q || op == DP_DIV_E) |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_mode != MODE_FIXED) |-> (r_steps <= i_cap || r_steps == 1))
        else $error("step count ran past iteration cap");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_mode == MODE_FIXED) |-> r_steps <= r_cnt)
        else $error("fixed count mode overran its count");
`endif

endmodule

FILE: hdl/polynomial_regula_falsi_root.sv
// Top level of the polynomial regula falsi root finder: stream ports, APB registers,
// output register. Depends on rfr_pkg, rfr_ctrl and rfr_dp.
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata 216b, tuser 1b (op)
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata 160b, tuser 2b (status)
// apb       in         psel/penable/pwrite (pready) 0x0 poly_degree, 0x4 iteration_cap
//
// Sequence: a solve runs Horner passes of n multiplies each (shift-add multiplier
// plus a 3-stage coefficient fetch), four of them at setup, two more before the loop,
// then per step one divide, one multiply, one Horner pass and the stop test (a divide
// and a multiply); fixed count mode runs the stop test only once at the end. One item
// is worked at a time.
// Reset: synchronous active low; registers return to degree 0 and cap 1000, no clearing
// pass; coefficients must be loaded before they are used.
// Stalls: a finished result sits in the output register; the next item is accepted
// meanwhile, and a later result waits in the controller until the register frees.
module polynomial_regula_falsi_root import rfr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // lsb up: coef_index 6, coef_value 48, interval_low 48, interval_high 48,
    // stop_mode 2, tolerance 47, iteration_count 16, pad 1
    input  logic [215:0] s_axis_tdata,
    // op
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // lsb up: root 48, error_apriori 47, error_posterior 47, iterations_used 16, pad 2
    output logic [159:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    // input field offsets
    localparam int P_VAL  = AW;
    localparam int P_LO   = P_VAL + VW;
    localparam int P_HI   = P_LO + VW;
    localparam int P_MODE = P_HI + VW;
    localparam int P_TOL  = P_MODE + 2;
    localparam int P_CNT  = P_TOL + VW - 1;
    localparam int IN_USED  = P_CNT + CW;
    localparam int OUT_USED = VW + 2 * (VW - 1) + CW;

    localparam logic [CW-1:0] CAP_RESET = CW'(1000);

    logic [AW-1:0] r_degree;
    logic [CW-1:0] r_cap;
    logic          cfg_wr, in_accept, ready, done, out_free;
    t_cmd          cmd;
    t_sts          sts;
    logic [1:0]    status;
    logic [CW-1:0] iters;
    t_val          root;
    logic [VW-2:0] err_a, err_p;

    logic          r_ovalid;
    t_val          r_root;
    logic [VW-2:0] r_err_a, r_err_p;
    logic [CW-1:0] r_iters;
    logic [1:0]    r_status;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_cap    <= CAP_RESET;
        end else if (cfg_wr) begin
            if (!paddr[2]) r_degree <= pwdata[AW-1:0];
            else           r_cap    <= pwdata[CW-1:0];
        end
    end

    assign prdata = paddr[2] ? {{(32-CW){1'b0}}, r_cap} : {{(32-AW){1'b0}}, r_degree};

    assign s_axis_tready = ready;
    assign in_accept     = s_axis_tvalid && ready;

    rfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_op       (s_axis_tuser[0]),
        .i_mode     (s_axis_tdata[P_MODE +: 2]),
        .i_count    (s_axis_tdata[P_CNT +: CW]),
        .i_degree   (r_degree),
        .i_cap      (r_cap),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ready    (ready),
        .o_cmd      (cmd),
        .o_done     (done),
        .o_status   (status),
        .o_iters    (iters)
    );

    rfr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_coef_index    (s_axis_tdata[0 +: AW]),
        .i_coef_value    (t_val'(s_axis_tdata[P_VAL +: VW])),
        .i_lo            (t_val'(s_axis_tdata[P_LO +: VW])),
        .i_hi            (t_val'(s_axis_tdata[P_HI +: VW])),
        .i_tol           (s_axis_tdata[P_TOL +: VW-1]),
        .o_sts           (sts),
        .o_root          (root),
        .o_err_apriori   (err_a),
        .o_err_posterior (err_p)
    );

    // output register: takes the result the cycle the controller hands it over
    assign out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)           r_ovalid <= 1'b0;
        else if (done)          r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_root   <= root;
            r_err_a  <= err_a;
            r_err_p  <= err_p;
            r_iters  <= iters;
            r_status <= status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(160-OUT_USED){1'b0}}, r_iters, r_err_p, r_err_a, r_root};
    assign m_axis_tuser  = r_status;

    // pad bit of the input word carries nothing
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[215:IN_USED];

endmodule
